>>> src/ils_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types, codes and helpers for the init list sequencer.
// ----------------------------------------------------------------------------
package ils_pkg;

   localparam int WORD_W   = 8;
   localparam int KIND_W   = 2;
   localparam int FRAME_W  = 9;
   localparam int MS_W     = 16;
   localparam int CMDS_W   = 8;
   localparam int ARGS_W   = 7;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [WORD_W-1:0] LONG_CODE_RESET = 8'd255;
   localparam logic [MS_W-1:0]   LONG_MS_RESET   = 16'd500;

   localparam logic [CSR_IDX_W-1:0] CSR_LONG_CODE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_MS   = 4'd1;

   localparam logic [KIND_W-1:0] KIND_CMD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELAY = 2'd2;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd3;

   typedef enum logic [4:0] {
      PH_COUNT  = 5'b00001,
      PH_OPCODE = 5'b00010,
      PH_ARGCNT = 5'b00100,
      PH_ARGS   = 5'b01000,
      PH_DELAY  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FRAME_W-1:0] frame;
      logic [MS_W-1:0]    delay_ms;
      logic               list_done;
   } result_type;

   typedef struct packed {
      logic [WORD_W-1:0] long_code;
      logic [MS_W-1:0]   long_ms;
   } cfg_type;

   function automatic logic [WORD_W-1:0] rev8(input logic [WORD_W-1:0] b);
      logic [WORD_W-1:0] r;
      for (int i = 0; i < WORD_W; i++) begin
         r[WORD_W-1-i] = b[i];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> src/ils_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ils_in_stage
// Input register: holds one list word until the decoder consumes it.
// ----------------------------------------------------------------------------
module ils_in_stage import ils_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [WORD_W-1:0] req_list_word,
   output logic                   word_valid,
   output logic [WORD_W-1:0]      word,
   input  wire logic              word_take
);

   logic              valid_ff, valid_in;
   logic [WORD_W-1:0] word_ff, word_in;

   assign req_ready  = !valid_ff || word_take;
   assign word_valid = valid_ff;
   assign word       = word_ff;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (word_take) begin
         valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         word_in  = req_list_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

endmodule
`default_nettype wire

>>> src/ils_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ils_decoder
// Phase machine over the init list; turns one word into at most one result.
// ----------------------------------------------------------------------------
module ils_decoder import ils_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire logic [WORD_W-1:0] word,
   input  wire cfg_type           cfg,
   output logic                   res_valid,
   output result_type             res
);

   phase_type         phase_ff, phase_in;
   logic [CMDS_W-1:0] cmds_ff, cmds_in;
   logic [ARGS_W-1:0] args_ff, args_in;
   logic              dly_ff, dly_in;
   logic [CMDS_W-1:0] cmds_dec;
   logic [ARGS_W-1:0] args_dec;
   logic              last_cmd;

   assign cmds_dec = cmds_ff - 1'b1;
   assign args_dec = args_ff - 1'b1;
   assign last_cmd = (cmds_dec == '0);

   always_comb begin
      phase_in  = phase_ff;
      cmds_in   = cmds_ff;
      args_in   = args_ff;
      dly_in    = dly_ff;
      res_valid = 1'b0;
      res       = '0;
      unique case (phase_ff)
         PH_OPCODE: begin
            res_valid = 1'b1;
            res.kind  = KIND_CMD;
            res.frame = {rev8(word), 1'b0};
            phase_in  = PH_ARGCNT;
         end
         PH_ARGCNT: begin
            args_in = word[ARGS_W-1:0];
            dly_in  = word[WORD_W-1];
            if (word[ARGS_W-1:0] != '0) begin
               phase_in = PH_ARGS;
            end else if (word[WORD_W-1]) begin
               phase_in = PH_DELAY;
            end else begin
               cmds_in = cmds_dec;
               if (last_cmd) begin
                  phase_in      = PH_COUNT;
                  res_valid     = 1'b1;
                  res.kind      = KIND_END;
                  res.list_done = 1'b1;
               end else begin
                  phase_in = PH_OPCODE;
               end
            end
         end
         PH_ARGS: begin
            args_in   = args_dec;
            res_valid = 1'b1;
            res.kind  = KIND_DATA;
            res.frame = {rev8(word), 1'b1};
            if (args_dec == '0) begin
               if (dly_ff) begin
                  phase_in = PH_DELAY;
               end else begin
                  cmds_in       = cmds_dec;
                  phase_in      = last_cmd ? PH_COUNT : PH_OPCODE;
                  res.list_done = last_cmd;
               end
            end
         end
         PH_DELAY: begin
            dly_in        = 1'b0;
            cmds_in       = cmds_dec;
            phase_in      = last_cmd ? PH_COUNT : PH_OPCODE;
            res_valid     = 1'b1;
            res.kind      = KIND_DELAY;
            res.delay_ms  = (word == cfg.long_code) ? cfg.long_ms
                                                    : {{(MS_W-WORD_W){1'b0}}, word};
            res.list_done = last_cmd;
         end
         default: begin
            cmds_in = word;
            args_in = '0;
            dly_in  = 1'b0;
            if (word == '0) begin
               phase_in      = PH_COUNT;
               res_valid     = 1'b1;
               res.kind      = KIND_END;
               res.list_done = 1'b1;
            end else begin
               phase_in = PH_OPCODE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COUNT;
         cmds_ff  <= '0;
         args_ff  <= '0;
         dly_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         cmds_ff  <= cmds_in;
         args_ff  <= args_in;
         dly_ff   <= dly_in;
      end
   end

endmodule
`default_nettype wire

>>> src/ils_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ils_out_stage
// Result register: holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module ils_out_stage import ils_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic load,
   input  wire result_type load_res,
   output logic      space,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output result_type rsp_res
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign space     = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         res_in   = load_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

endmodule
`default_nettype wire

>>> src/init_list_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// init_list_sequencer
// Plays a packed display init list one byte per transaction.
//
// req_* carries one list word per transaction. rsp_* returns zero or one
// result per word: command frame, data frame, delay, or end marker, with
// list_done on the result of the last word of a list. Count and argument
// count words normally give no result.
// csr_* writes long_delay_code (index 0) and long_delay_ms (index 1); it is
// always ready and must be used only while the block is idle.
// An accepted word waits in the input register, then is decoded into the
// result register once it has space; the receiver takes the result there.
// Throughput: one word per cycle while the receiver keeps up; the only
// loop is the phase machine update. Reset clears the phase to expect a
// command count, empties both registers and restores the delay settings.
// When the receiver stalls, the result register holds, the input register
// fills, and req_ready drops.
// ----------------------------------------------------------------------------
module init_list_sequencer import ils_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [WORD_W-1:0]     req_list_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [KIND_W-1:0]          rsp_kind,
   output logic [FRAME_W-1:0]         rsp_frame,
   output logic [MS_W-1:0]            rsp_delay_ms,
   output logic                       rsp_list_done,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type           cfg_ff, cfg_in;
   logic              word_valid;
   logic [WORD_W-1:0] word;
   logic              space;
   logic              fire;
   logic              res_valid;
   result_type        res;
   result_type        rsp_res;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LONG_CODE: cfg_in.long_code = csr_wdata[WORD_W-1:0];
            CSR_LONG_MS:   cfg_in.long_ms   = csr_wdata[MS_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_code <= LONG_CODE_RESET;
         cfg_ff.long_ms   <= LONG_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign fire = word_valid && space;

   ils_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_list_word (req_list_word),
      .word_valid    (word_valid),
      .word          (word),
      .word_take     (fire)
   );

   ils_decoder u_dec (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .word      (word),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   ils_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && res_valid),
      .load_res  (res),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_res   (rsp_res)
   );

   assign rsp_kind      = rsp_res.kind;
   assign rsp_frame     = rsp_res.frame;
   assign rsp_delay_ms  = rsp_res.delay_ms;
   assign rsp_list_done = rsp_res.list_done;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !word_valid)
      else $error("pipeline not empty after reset");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !word_valid |-> req_ready)
      else $error("input stalled while empty");

   a_delay_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_DELAY |-> rsp_delay_ms == '0)
      else $error("delay value on a non-delay result");

   a_frame_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame[0] == (rsp_kind == KIND_DATA)) &&
                    ((rsp_kind != KIND_DELAY && rsp_kind != KIND_END) ||
                     rsp_frame == '0))
      else $error("frame inconsistent with kind");

endmodule
`default_nettype wire
